[hw/rtl/l1_release_coherence_ctrl_unit_macros.svh]
// Assertion macros shared by the L1 release coherence controller RTL.
`ifndef L1_RELEASE_COHERENCE_CTRL_UNIT_MACROS_SVH
`define L1_RELEASE_COHERENCE_CTRL_UNIT_MACROS_SVH
`ifndef SYNTH
`define L1RC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("l1rc check failed");
`define L1RC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("l1rc check failed");
`else
`define L1RC_ASSERT_IMP(lbl, ante, cons)
`define L1RC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/l1rc_pkg.sv]
// Types and constants of the L1 release coherence controller.
`timescale 1ns / 1ps
`default_nettype none
package l1rc_pkg;
    localparam logic [2:0] KIND_LOAD    = 3'd0;
    localparam logic [2:0] KIND_STORE   = 3'd1;
    localparam logic [2:0] KIND_ACQUIRE = 3'd2;
    localparam logic [2:0] KIND_RELEASE = 3'd3;
    localparam logic [2:0] KIND_DATA    = 3'd4;
    localparam logic [2:0] KIND_WB_REQ  = 3'd5;
    localparam logic [2:0] KIND_INVAL   = 3'd6;

    localparam logic [1:0] MSG_GETV = 2'd0;
    localparam logic [1:0] MSG_GETO = 2'd1;
    localparam logic [1:0] MSG_WB   = 2'd2;
    localparam logic [1:0] MSG_HIT  = 2'd3;

    localparam int MAX_RESULTS = 8;
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        address;
        logic signed [31:0] value;
        logic               req_scope;
    } msg_t;
endpackage
`default_nettype wire

[hw/rtl/l1_release_coherence_ctrl_unit.sv]
// Top level of the L1 release coherence controller: block state and sequencer.
// Use: the s_ channel carries processor requests and L2 messages (kind,
// address, data, scope, ownership grant, flush flag); the m_ channel returns
// GetV, GetO, write-back and hit-data messages, the last of an item flagged
// by m_last. cfg_we/cfg_wdata set the cache number sent as m_source_number.
// Flow: an accepted item passes through the lookup step, then for a
// GPU release, a GPU-scope data response or a flushing write-back request a
// scan of all BLOCK_COUNT entries, one entry a cycle while the output has
// room, through the shared tag and state check, then the closing step.
// s_ready is high only between items. The final message leaves the holding
// slot in the closing step and appears on m_ in the cycle after.
// Stall: when m_ready is low the sequencer waits whenever a new message has
// no room; nothing is dropped except messages beyond eight per item.
// Reset: valid, dirty and owned bits clear, cache number is 0, output empty.
`timescale 1ns / 1ps
`default_nettype none
`include "l1_release_coherence_ctrl_unit_macros.svh"
module l1_release_coherence_ctrl_unit #(
    parameter int BLOCK_COUNT = 8,
    parameter int NUM_CACHES = 4
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [$clog2(NUM_CACHES)-1:0]   cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [2:0]                      s_kind,
    input  wire logic [31:0]                     s_address,
    input  wire logic signed [31:0]              s_data_value,
    input  wire logic                            s_gpu_scope,
    input  wire logic                            s_grants_owned,
    input  wire logic                            s_flush_others,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [1:0]                           m_msg_kind,
    output logic [31:0]                          m_msg_address,
    output logic signed [31:0]                   m_msg_value,
    output logic                                 m_msg_gpu_scope,
    output logic [$clog2(NUM_CACHES)-1:0]        m_source_number,
    output logic                                 m_last
);
    localparam int IW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_FIRST, ST_SCAN, ST_FINISH} state_t;

    state_t                state_reg;
    logic                  mode_inv_reg;   // scan self-invalidates, else flushes
    logic [IW-1:0]         scan_reg;
    logic [l1rc_pkg::CNT_W-1:0] cnt_reg;
    logic [$clog2(NUM_CACHES)-1:0] cache_num_reg;

    logic [2:0]            kind_reg;
    logic [31:0]           addr_reg;
    logic signed [31:0]    val_reg;
    logic                  gpu_reg;
    logic                  grant_reg;
    logic                  others_reg;

    logic [31:0]           tag_mem [BLOCK_COUNT];
    logic signed [31:0]    data_mem [BLOCK_COUNT];
    logic [BLOCK_COUNT-1:0] valid_reg;
    logic [BLOCK_COUNT-1:0] dirty_reg;
    logic [BLOCK_COUNT-1:0] owned_reg;

    logic                  hit;
    logic [IW-1:0]         hidx;
    logic                  inv_any;
    logic [IW-1:0]         inv_idx;
    logic [IW-1:0]         rd_idx;
    logic                  emit_req;
    l1rc_pkg::msg_t        emit_msg;
    logic                  drop;
    logic                  emit_go;
    logic                  q_push;
    logic                  q_can_push;
    logic                  q_close_ok;
    logic                  q_empty;
    logic                  scan_cond;

    // parallel tag match and free-entry search
    always_comb begin
        hit     = 1'b0;
        hidx    = '0;
        inv_any = 1'b0;
        inv_idx = '0;
        for (int i = BLOCK_COUNT - 1; i >= 0; i--) begin
            if (valid_reg[i] && tag_mem[i] == addr_reg) begin
                hit  = 1'b1;
                hidx = IW'(i);
            end
            if (!valid_reg[i]) begin
                inv_any = 1'b1;
                inv_idx = IW'(i);
            end
        end
    end

    assign rd_idx = (state_reg == ST_SCAN) ? scan_reg : (hit ? hidx : '0);

    always_comb begin
        emit_req  = 1'b0;
        emit_msg  = '0;
        scan_cond = 1'b0;
        unique case (state_reg)
            ST_FIRST: begin
                unique case (kind_reg)
                    l1rc_pkg::KIND_LOAD: begin
                        emit_req = 1'b1;
                        emit_msg.address = addr_reg;
                        if (hit) begin
                            emit_msg.kind  = l1rc_pkg::MSG_HIT;
                            emit_msg.value = data_mem[rd_idx];
                        end else begin
                            emit_msg.kind      = l1rc_pkg::MSG_GETV;
                            emit_msg.req_scope = gpu_reg;
                        end
                    end
                    l1rc_pkg::KIND_STORE: begin
                        emit_req           = !(hit && owned_reg[hidx]);
                        emit_msg.kind      = l1rc_pkg::MSG_GETO;
                        emit_msg.address   = addr_reg;
                        emit_msg.req_scope = gpu_reg;
                    end
                    l1rc_pkg::KIND_ACQUIRE: begin
                        emit_req           = gpu_reg || !hit;
                        emit_msg.kind      = l1rc_pkg::MSG_GETV;
                        emit_msg.address   = addr_reg;
                        emit_msg.req_scope = gpu_reg;
                    end
                    l1rc_pkg::KIND_RELEASE, l1rc_pkg::KIND_WB_REQ: begin
                        emit_req = hit && dirty_reg[hidx] &&
                                   (gpu_reg || kind_reg == l1rc_pkg::KIND_WB_REQ);
                        emit_msg.kind    = l1rc_pkg::MSG_WB;
                        emit_msg.address = addr_reg;
                        emit_msg.value   = data_mem[rd_idx];
                    end
                    l1rc_pkg::KIND_DATA: begin
                        // victim is entry 0 when nothing matches and nothing is free
                        emit_req = !hit && !inv_any && dirty_reg[0];
                        emit_msg.kind    = l1rc_pkg::MSG_WB;
                        emit_msg.address = tag_mem[0];
                        emit_msg.value   = data_mem[rd_idx];
                    end
                    default: begin
                        emit_req = 1'b0;
                    end
                endcase
            end
            ST_SCAN: begin
                if (mode_inv_reg) begin
                    scan_cond = valid_reg[scan_reg] && !owned_reg[scan_reg] &&
                                tag_mem[scan_reg] != addr_reg;
                    emit_req  = scan_cond && dirty_reg[scan_reg];
                end else begin
                    scan_cond = valid_reg[scan_reg] && dirty_reg[scan_reg] &&
                                !owned_reg[scan_reg];
                    emit_req  = scan_cond;
                end
                emit_msg.kind    = l1rc_pkg::MSG_WB;
                emit_msg.address = tag_mem[scan_reg];
                emit_msg.value   = data_mem[rd_idx];
            end
            default: begin
                emit_req = 1'b0;
            end
        endcase
    end

    assign drop    = cnt_reg >= l1rc_pkg::CNT_W'(l1rc_pkg::MAX_RESULTS);
    assign emit_go = !emit_req || drop || q_can_push;
    assign q_push  = emit_req && !drop;
    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            owned_reg     <= '0;
            cnt_reg       <= '0;
            cache_num_reg <= '0;
            scan_reg      <= '0;
            mode_inv_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                cache_num_reg <= cfg_wdata;
            end
            if (q_push && q_can_push) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        kind_reg   <= s_kind;
                        addr_reg   <= s_address;
                        val_reg    <= s_data_value;
                        gpu_reg    <= s_gpu_scope;
                        grant_reg  <= s_grants_owned;
                        others_reg <= s_flush_others;
                        cnt_reg    <= '0;
                        state_reg  <= ST_FIRST;
                    end
                end
                ST_FIRST: begin
                    if (emit_go) begin
                        state_reg <= ST_FINISH;
                        scan_reg  <= '0;
                        unique case (kind_reg)
                            l1rc_pkg::KIND_STORE: begin
                                if (hit && owned_reg[hidx]) begin
                                    data_mem[hidx]  <= val_reg;
                                    dirty_reg[hidx] <= 1'b1;
                                end
                            end
                            l1rc_pkg::KIND_RELEASE: begin
                                if (gpu_reg) begin
                                    if (hit && dirty_reg[hidx]) begin
                                        dirty_reg[hidx] <= 1'b0;
                                        owned_reg[hidx] <= 1'b1;
                                    end
                                    mode_inv_reg <= 1'b0;
                                    state_reg    <= ST_SCAN;
                                end
                            end
                            l1rc_pkg::KIND_DATA: begin
                                if (hit) begin
                                    data_mem[hidx]  <= val_reg;
                                    dirty_reg[hidx] <= 1'b0;
                                    owned_reg[hidx] <= grant_reg;
                                end else if (inv_any) begin
                                    tag_mem[inv_idx]   <= addr_reg;
                                    data_mem[inv_idx]  <= val_reg;
                                    valid_reg[inv_idx] <= 1'b1;
                                    dirty_reg[inv_idx] <= 1'b0;
                                    owned_reg[inv_idx] <= grant_reg;
                                end else begin
                                    tag_mem[0]   <= addr_reg;
                                    data_mem[0]  <= val_reg;
                                    dirty_reg[0] <= 1'b0;
                                    owned_reg[0] <= grant_reg;
                                end
                                if (gpu_reg) begin
                                    mode_inv_reg <= 1'b1;
                                    state_reg    <= ST_SCAN;
                                end
                            end
                            l1rc_pkg::KIND_WB_REQ: begin
                                if (hit && dirty_reg[hidx]) begin
                                    dirty_reg[hidx] <= 1'b0;
                                    if (owned_reg[hidx] && others_reg) begin
                                        mode_inv_reg <= 1'b0;
                                        state_reg    <= ST_SCAN;
                                    end
                                end
                            end
                            l1rc_pkg::KIND_INVAL: begin
                                if (hit) begin
                                    valid_reg[hidx] <= 1'b0;
                                    dirty_reg[hidx] <= 1'b0;
                                    owned_reg[hidx] <= 1'b0;
                                end
                            end
                            default: begin
                                state_reg <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (emit_go) begin
                        if (scan_cond) begin
                            dirty_reg[scan_reg] <= 1'b0;
                            if (mode_inv_reg) begin
                                valid_reg[scan_reg] <= 1'b0;
                            end
                        end
                        if (scan_reg == IW'(BLOCK_COUNT - 1)) begin
                            state_reg <= ST_FINISH;
                        end else begin
                            scan_reg <= scan_reg + 1'b1;
                        end
                    end
                end
                ST_FINISH: begin
                    if (q_close_ok) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    l1rc_msg_q u_msg_q (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .push            (q_push),
        .push_msg        (emit_msg),
        .close           (state_reg == ST_FINISH),
        .can_push        (q_can_push),
        .close_ok        (q_close_ok),
        .empty           (q_empty),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_msg_kind      (m_msg_kind),
        .m_msg_address   (m_msg_address),
        .m_msg_value     (m_msg_value),
        .m_msg_gpu_scope (m_msg_gpu_scope),
        .m_last          (m_last)
    );

    assign m_source_number = cache_num_reg;

    `L1RC_ASSERT_IMP(a_idle_slot_empty, state_reg == ST_IDLE, q_empty)
    `L1RC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= l1rc_pkg::CNT_W'(l1rc_pkg::MAX_RESULTS))
    `L1RC_ASSERT_NXT(a_accept_lookup, s_valid && s_ready, state_reg == ST_FIRST)
endmodule
`default_nettype wire

[hw/rtl/l1rc_msg_q.sv]
// One-deep holding slot plus output register; marks the final message of an item.
`timescale 1ns / 1ps
`default_nettype none
module l1rc_msg_q (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire l1rc_pkg::msg_t     push_msg,
    input  wire logic               close,
    output logic                    can_push,
    output logic                    close_ok,
    output logic                    empty,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_msg_kind,
    output logic [31:0]             m_msg_address,
    output logic signed [31:0]      m_msg_value,
    output logic                    m_msg_gpu_scope,
    output logic                    m_last
);
    l1rc_pkg::msg_t pend_reg;
    logic           pend_v_reg;
    l1rc_pkg::msg_t out_reg;
    logic           out_v_reg;
    logic           last_reg;
    logic           out_free;

    assign out_free = !out_v_reg || m_ready;
    assign can_push = !pend_v_reg || out_free;
    assign close_ok = !pend_v_reg || out_free;
    assign empty    = !pend_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            if (push && can_push) begin
                if (pend_v_reg) begin
                    out_reg   <= pend_reg;
                    last_reg  <= 1'b0;
                    out_v_reg <= 1'b1;
                end else if (m_ready) begin
                    out_v_reg <= 1'b0;
                end
                pend_reg   <= push_msg;
                pend_v_reg <= 1'b1;
            end else if (close && pend_v_reg && out_free) begin
                out_reg    <= pend_reg;
                last_reg   <= 1'b1;
                out_v_reg  <= 1'b1;
                pend_v_reg <= 1'b0;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = out_v_reg;
    assign m_msg_kind      = out_reg.kind;
    assign m_msg_address   = out_reg.address;
    assign m_msg_value     = out_reg.value;
    assign m_msg_gpu_scope = out_reg.req_scope;
    assign m_last          = last_reg;
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench of the L1 release coherence controller.
`timescale 1ns / 1ps
module tb_top;
    localparam int NBLK = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0]         kind;
        logic [31:0]        address;
        logic signed [31:0] data_value;
        logic               gpu_req;
        logic               grants_owned;
        logic               flush_others;
    } req_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        address;
        logic [31:0]        value;
        logic               scope;
        logic [1:0]         source;
        logic               last;
    } l2_msg_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_kind = '0;
    logic [31:0] s_address = '0;
    logic signed [31:0] s_data_value = '0;
    logic s_gpu_scope = 1'b0;
    logic s_grants_owned = 1'b0;
    logic s_flush_others = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_msg_kind;
    logic [31:0] m_msg_address;
    logic signed [31:0] m_msg_value;
    logic m_msg_gpu_scope;
    logic [1:0] m_source_number;
    logic m_last;

    always #5 aclk = ~aclk;

    l1_release_coherence_ctrl_unit #(.BLOCK_COUNT(NBLK), .NUM_CACHES(4)) i_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_address(s_address),
        .s_data_value(s_data_value), .s_gpu_scope(s_gpu_scope),
        .s_grants_owned(s_grants_owned), .s_flush_others(s_flush_others),
        .m_valid(m_valid), .m_ready(m_ready), .m_msg_kind(m_msg_kind),
        .m_msg_address(m_msg_address), .m_msg_value(m_msg_value),
        .m_msg_gpu_scope(m_msg_gpu_scope), .m_source_number(m_source_number),
        .m_last(m_last)
    );

    // shadow copy of the cache
    logic [31:0] tags [NBLK];
    logic [31:0] blk_data [NBLK];
    logic [NBLK-1:0] vld, drt, own;
    logic [1:0] src_id;

    l2_msg_t expected_msgs[$];
    l2_msg_t item_msgs[$];
    int errors = 0;
    int idle_cycles = 0;
    logic [31:0] addr_pool [6];

    function automatic void push_msg(logic [1:0] k, logic [31:0] a, logic [31:0] v,
                                     logic sc);
        l2_msg_t m;
        if (item_msgs.size() >= l1rc_pkg::MAX_RESULTS) return;
        m.kind = k; m.address = a; m.value = v; m.scope = sc;
        m.source = src_id; m.last = 1'b0;
        item_msgs = {item_msgs, m};
    endfunction

    function automatic int find_blk(logic [31:0] a);
        for (int i = 0; i < NBLK; i++)
            if (vld[i] && tags[i] == a) return i;
        return -1;
    endfunction

    function automatic void flush_shared();
        for (int i = 0; i < NBLK; i++)
            if (vld[i] && drt[i] && !own[i]) begin
                push_msg(l1rc_pkg::MSG_WB, tags[i], blk_data[i], 1'b0);
                drt[i] = 1'b0;
            end
    endfunction

    function automatic void predict_coherence(req_t r);
        int idx;
        item_msgs.delete();
        idx = find_blk(r.address);
        case (r.kind)
            l1rc_pkg::KIND_LOAD:
                if (idx >= 0) push_msg(l1rc_pkg::MSG_HIT, r.address, blk_data[idx], 1'b0);
                else push_msg(l1rc_pkg::MSG_GETV, r.address, '0, r.gpu_req);
            l1rc_pkg::KIND_STORE:
                if (idx >= 0 && own[idx]) begin
                    blk_data[idx] = r.data_value;
                    drt[idx] = 1'b1;
                end else push_msg(l1rc_pkg::MSG_GETO, r.address, '0, r.gpu_req);
            l1rc_pkg::KIND_ACQUIRE:
                if (r.gpu_req) push_msg(l1rc_pkg::MSG_GETV, r.address, '0, 1'b1);
                else if (idx < 0) push_msg(l1rc_pkg::MSG_GETV, r.address, '0, 1'b0);
            l1rc_pkg::KIND_RELEASE:
                if (r.gpu_req) begin
                    if (idx >= 0 && drt[idx]) begin
                        push_msg(l1rc_pkg::MSG_WB, tags[idx], blk_data[idx], 1'b0);
                        drt[idx] = 1'b0;
                        own[idx] = 1'b1;
                    end
                    flush_shared();
                end
            l1rc_pkg::KIND_DATA: begin
                if (idx < 0) begin
                    for (int i = 0; i < NBLK; i++)
                        if (!vld[i]) begin idx = i; break; end
                    if (idx < 0) begin
                        idx = 0;
                        if (drt[0]) push_msg(l1rc_pkg::MSG_WB, tags[0], blk_data[0], 1'b0);
                    end
                    tags[idx] = r.address;
                end
                blk_data[idx] = r.data_value;
                vld[idx] = 1'b1;
                drt[idx] = 1'b0;
                if (r.gpu_req)
                    for (int i = 0; i < NBLK; i++)
                        if (vld[i] && !own[i] && tags[i] != r.address) begin
                            if (drt[i])
                                push_msg(l1rc_pkg::MSG_WB, tags[i], blk_data[i], 1'b0);
                            vld[i] = 1'b0;
                            drt[i] = 1'b0;
                        end
                own[idx] = r.grants_owned;
            end
            l1rc_pkg::KIND_WB_REQ:
                if (idx >= 0 && drt[idx]) begin
                    push_msg(l1rc_pkg::MSG_WB, tags[idx], blk_data[idx], 1'b0);
                    if (own[idx] && r.flush_others) flush_shared();
                    drt[idx] = 1'b0;
                end
            l1rc_pkg::KIND_INVAL:
                if (idx >= 0) begin
                    vld[idx] = 1'b0; drt[idx] = 1'b0; own[idx] = 1'b0;
                end
            default: ;
        endcase
        if (item_msgs.size() > 0) item_msgs[item_msgs.size()-1].last = 1'b1;
        expected_msgs = {expected_msgs, item_msgs};
    endfunction

    task automatic send_item(req_t r);
        s_valid <= 1'b1;
        s_kind <= r.kind;
        s_address <= r.address;
        s_data_value <= r.data_value;
        s_gpu_scope <= r.gpu_req;
        s_grants_owned <= r.grants_owned;
        s_flush_others <= r.flush_others;
        do @(posedge aclk); while (!s_ready);
        predict_coherence(r);
        // burst/gap pacing
        if ($urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (expected_msgs.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_src_id(logic [1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        src_id = v;
    endtask

    function automatic req_t make_req(logic [2:0] k, logic [31:0] a, logic [31:0] d,
                                      logic g, logic o, logic f);
        req_t r;
        r.kind = k; r.address = a; r.data_value = d;
        r.gpu_req = g; r.grants_owned = o; r.flush_others = f;
        return r;
    endfunction

    // receiver stalls on its own pattern
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 9) < 7) || (idle_cycles > 50);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_msgs.size() == 0) begin
                $error("unexpected message kind %0d addr %h", m_msg_kind, m_msg_address);
                errors++;
            end else begin
                l2_msg_t e;
                e = expected_msgs.pop_front();
                if (m_msg_kind != e.kind) begin
                    $error("msg_kind exp %0d got %0d", e.kind, m_msg_kind); errors++;
                end
                if (m_msg_address != e.address) begin
                    $error("msg_address exp %h got %h", e.address, m_msg_address); errors++;
                end
                if (m_msg_value != e.value) begin
                    $error("msg_value exp %h got %h", e.value, m_msg_value); errors++;
                end
                if (m_msg_gpu_scope != e.scope) begin
                    $error("msg_gpu_scope exp %0d got %0d", e.scope, m_msg_gpu_scope);
                    errors++;
                end
                if (m_source_number != e.source) begin
                    $error("source_number exp %0d got %0d", e.source, m_source_number);
                    errors++;
                end
                if (m_last != e.last) begin
                    $error("last exp %0d got %0d", e.last, m_last); errors++;
                end
            end
        end
    end

    // watchdog on accepted traffic
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_directed_basics();
        write_src_id(2'd3);
        send_item(make_req(l1rc_pkg::KIND_LOAD, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0));
        send_item(make_req(l1rc_pkg::KIND_LOAD, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, 1'b0));
        send_item(make_req(l1rc_pkg::KIND_STORE, 32'h10, 32'h1, 1'b1, 1'b0, 1'b0));
        send_item(make_req(l1rc_pkg::KIND_DATA, 32'h10, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0));
        send_item(make_req(l1rc_pkg::KIND_STORE, 32'h10, 32'h8000_0000, 1'b0, 1'b0, 1'b0));
        send_item(make_req(l1rc_pkg::KIND_LOAD, 32'h10, 32'h0, 1'b0, 1'b0, 1'b0));
        send_item(make_req(l1rc_pkg::KIND_ACQUIRE, 32'h10, 32'h0, 1'b0, 1'b0, 1'b0));
        send_item(make_req(l1rc_pkg::KIND_ACQUIRE, 32'h20, 32'h0, 1'b0, 1'b0, 1'b0));
        send_item(make_req(l1rc_pkg::KIND_ACQUIRE, 32'h10, 32'h0, 1'b1, 1'b0, 1'b0));
        send_item(make_req(l1rc_pkg::KIND_DATA, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           1'b0, 1'b0, 1'b1));
        send_item(make_req(l1rc_pkg::KIND_RELEASE, 32'h10, 32'h0, 1'b0, 1'b0, 1'b0));
        send_item(make_req(l1rc_pkg::KIND_WB_REQ, 32'h10, 32'h0, 1'b0, 1'b0, 1'b1));
        send_item(make_req(l1rc_pkg::KIND_STORE, 32'h10, 32'h55, 1'b0, 1'b0, 1'b0));
        send_item(make_req(l1rc_pkg::KIND_RELEASE, 32'h10, 32'h0, 1'b1, 1'b0, 1'b0));
        send_item(make_req(l1rc_pkg::KIND_INVAL, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 1'b0));
        send_item(make_req(KIND_UNUSED, 32'h10, 32'h0, 1'b1, 1'b1, 1'b1));
        drain_and_settle();
    endtask

    // fill every entry, dirty the owned ones, then force eviction and GPU flushes
    task automatic test_full_cache_eviction();
        write_src_id(2'd1);
        for (int i = 0; i < NBLK; i++)
            send_item(make_req(l1rc_pkg::KIND_DATA, 32'h100 + i, i, 1'b0, 1'b1, 1'b0));
        for (int i = 0; i < NBLK; i++)
            send_item(make_req(l1rc_pkg::KIND_STORE, 32'h100 + i, 32'hA0 + i,
                               1'b0, 1'b0, 1'b0));
        send_item(make_req(l1rc_pkg::KIND_DATA, 32'h200, 32'h1234, 1'b1, 1'b0, 1'b0));
        send_item(make_req(l1rc_pkg::KIND_WB_REQ, 32'h101, 32'h0, 1'b0, 1'b0, 1'b1));
        send_item(make_req(l1rc_pkg::KIND_RELEASE, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0));
        drain_and_settle();
    endtask

    task automatic test_random_traffic(int n, logic [1:0] id);
        req_t r;
        write_src_id(id);
        for (int i = 0; i < n; i++) begin
            r.address = ($urandom_range(0, 9) == 0) ? $urandom() :
                        addr_pool[$urandom_range(0, 5)];
            r.data_value = $urandom();
            r.gpu_req = 1'($urandom_range(0, 1));
            r.grants_owned = 1'($urandom_range(0, 1));
            r.flush_others = 1'($urandom_range(0, 1));
            // lean on fills and stores so blocks get owned and dirty
            case ($urandom_range(0, 11))
                0, 1:    r.kind = l1rc_pkg::KIND_LOAD;
                2, 3, 4: r.kind = l1rc_pkg::KIND_STORE;
                5:       r.kind = l1rc_pkg::KIND_ACQUIRE;
                6:       r.kind = l1rc_pkg::KIND_RELEASE;
                7, 8, 9: r.kind = l1rc_pkg::KIND_DATA;
                10:      r.kind = l1rc_pkg::KIND_WB_REQ;
                default: r.kind = ($urandom_range(0, 7) == 0) ? KIND_UNUSED :
                                  l1rc_pkg::KIND_INVAL;
            endcase
            if (r.kind == l1rc_pkg::KIND_DATA && $urandom_range(0, 2) != 0)
                r.gpu_req = 1'b0;
            send_item(r);
            if (i == n / 2) drain_and_settle();
        end
        drain_and_settle();
    endtask

    initial begin
        vld = '0; drt = '0; own = '0; src_id = 2'd0;
        foreach (tags[i]) begin tags[i] = '0; blk_data[i] = '0; end
        foreach (addr_pool[i]) addr_pool[i] = $urandom();
        addr_pool[0] = 32'h0;
        addr_pool[1] = 32'hFFFF_FFFF;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_basics();
        test_full_cache_eviction();
        test_random_traffic(90, 2'd0);
        test_random_traffic(90, 2'd2);
        test_random_traffic(30, 2'd3);
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/l1rc_pkg.sv
hw/rtl/l1rc_msg_q.sv
hw/rtl/l1_release_coherence_ctrl_unit.sv
tb/tb_top.sv
